### rtl/core/qts_pkg.sv
// Package for the queue telemetry statistics engine.
// Holds the item types, command and statistic codes, and the per-queue record.
// No dependencies.
package qts_pkg;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] PROTO_TCP = 2'd1;
    localparam logic [1:0] PROTO_UDP = 2'd2;

    localparam logic [1:0] COLOR_GREEN  = 2'd0;
    localparam logic [1:0] COLOR_YELLOW = 2'd1;
    localparam logic [1:0] COLOR_RED    = 2'd3;

    localparam int NUM_BINS = 10;
    localparam logic [31:0] DELAY_UNIT = 32'd262144;
    localparam logic [23:0] MAX_DEPTH_RESET = 24'd25000;
    localparam logic [31:0] HIST_LIMIT_RESET = 32'd25000;

    localparam logic CFG_MAX_DEPTH  = 1'b0;
    localparam logic CFG_HIST_LIMIT = 1'b1;

    localparam logic [4:0] ST_UDP_PKTS    = 5'd0;
    localparam logic [4:0] ST_UDP_BYTES   = 5'd1;
    localparam logic [4:0] ST_TCP_PKTS    = 5'd2;
    localparam logic [4:0] ST_TCP_BYTES   = 5'd3;
    localparam logic [4:0] ST_GREEN       = 5'd4;
    localparam logic [4:0] ST_YELLOW      = 5'd5;
    localparam logic [4:0] ST_RED         = 5'd6;
    localparam logic [4:0] ST_HIST_FIRST  = 5'd7;
    localparam logic [4:0] ST_HIST_LAST   = 5'd16;
    localparam logic [4:0] ST_DEPTH_SUM   = 5'd17;
    localparam logic [4:0] ST_DELAY_SUM   = 5'd18;
    localparam logic [4:0] ST_TRANS_SUM   = 5'd19;
    localparam logic [4:0] ST_DEPTH_MIN   = 5'd20;
    localparam logic [4:0] ST_DEPTH_MAX   = 5'd21;
    localparam logic [4:0] ST_DELAY_MIN   = 5'd22;
    localparam logic [4:0] ST_DELAY_MAX   = 5'd23;
    localparam logic [4:0] ST_TRANS_MIN   = 5'd24;
    localparam logic [4:0] ST_TRANS_MAX   = 5'd25;
    localparam logic [4:0] ST_G_TCP_PKTS  = 5'd26;
    localparam logic [4:0] ST_G_TCP_BYTES = 5'd27;
    localparam logic [4:0] ST_G_UDP_PKTS  = 5'd28;
    localparam logic [4:0] ST_G_UDP_BYTES = 5'd29;
    localparam logic [4:0] ST_INGRESS_SEQ = 5'd30;
    localparam logic [4:0] ST_EGRESS_SEQ  = 5'd31;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  protocol;
        logic [7:0]  qid;
        logic [15:0] pkt_bytes;
        logic [1:0]  color;
        logic [31:0] ingress_stamp;
        logic [31:0] egress_stamp;
        logic [31:0] enqueue_depth;
        logic [31:0] queue_delay;
        logic [31:0] ingress_seq_low;
        logic [31:0] egress_seq_low;
        logic [4:0]  stat_index;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [31:0] corrected_delay;
        logic        counted;
    } rsp_t;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } min_max_t;

    typedef struct packed {
        logic [31:0]               udp_pkts;
        logic [63:0]               udp_bytes;
        logic [31:0]               tcp_pkts;
        logic [63:0]               tcp_bytes;
        logic [2:0][31:0]          colors;
        logic [NUM_BINS-1:0][31:0] hist;
        logic [63:0]               depth_sum;
        logic [63:0]               delay_sum;
        logic [63:0]               trans_sum;
        min_max_t                  depth_mm;
        min_max_t                  delay_mm;
        min_max_t                  trans_mm;
    } queue_row_t;

    function automatic min_max_t track_min_max(min_max_t pair, logic [31:0] v);
        min_max_t res;
        logic     unset;
        unset = (pair.lo == 32'd0);
        res.lo = (unset || v < pair.lo) ? v : pair.lo;
        res.hi = (unset || v > pair.hi) ? v : pair.hi;
        return res;
    endfunction

    function automatic logic [63:0] extend_seq(logic [63:0] ext, logic [31:0] low);
        logic wrap;
        wrap = (low == 32'd0);
        return {ext[63:32] + {31'd0, wrap}, low};
    endfunction

endpackage

### rtl/core/qts_if.sv
// Handshake interfaces for the request and response channels.
// Depends on qts_pkg for the payload types.
interface qts_req_if
    import qts_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qts_rsp_if
    import qts_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/queue_telemetry_stats.sv
// An accepted item passes the input register, then the output register; one item per cycle unless the response stalls.
// The input register feeds one read-modify-write of the selected queue row.
// The output register decouples the response side; both stall together.
// Reset clears all statistics, the extended sequence numbers and the valids,
// and restores the configured maximum depth and histogram limit to 25000.
// Depends on qts_pkg and qts_if.
module queue_telemetry_stats
    import qts_pkg::*;
#(
    parameter int NUM_QUEUES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    qts_req_if.sink     req,
    qts_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic [QW-1:0]    qmap [256];
    logic [35:0]      edge_reg [NUM_BINS-1];
    logic [31:0]      limit_reg;
    logic             s1_valid_reg;
    req_t             s1_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;
    rsp_t             out_next;
    queue_row_t       row_reg [NUM_QUEUES];
    queue_row_t       row_next;
    queue_row_t       row_cur;
    logic [31:0]      g_tcp_pkts_reg, g_udp_pkts_reg;
    logic [63:0]      g_tcp_bytes_reg, g_udp_bytes_reg;
    logic [63:0]      iseq_reg, eseq_reg;
    logic [QW-1:0]    q;
    logic             advance;
    logic             do_count;
    logic             do_clear;
    logic [31:0]      transit;
    logic [31:0]      delay_c;
    logic [35:0]      depth10;
    logic [3:0]       bin;
    logic             bin_hit;
    logic [63:0]      len64;

    genvar gi;
    generate
        for (gi = 0; gi < 256; gi++)
        begin : g_qmap
            assign qmap[gi] = QW'(gi % NUM_QUEUES);
        end
    endgenerate

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign q        = qmap[s1_reg.qid];
    assign row_cur  = row_reg[q];
    assign do_count = s1_valid_reg && advance && (s1_reg.cmd == CMD_PACKET)
                      && (s1_reg.protocol == PROTO_TCP || s1_reg.protocol == PROTO_UDP);
    assign do_clear = s1_valid_reg && advance && (s1_reg.cmd == CMD_CLEAR);
    assign transit  = s1_reg.egress_stamp - s1_reg.ingress_stamp;
    assign depth10  = {1'b0, s1_reg.enqueue_depth, 3'b000}
                      + {3'b000, s1_reg.enqueue_depth, 1'b0};
    assign len64    = {48'd0, s1_reg.pkt_bytes};

    always_comb
    begin
        if ({1'b0, transit} > {s1_reg.queue_delay, 1'b0} && transit > DELAY_UNIT)
        begin
            delay_c = s1_reg.queue_delay + {transit[31:18], 18'd0};
        end
        else
        begin
            delay_c = s1_reg.queue_delay;
        end
    end

    always_comb
    begin
        bin = 4'(NUM_BINS - 1);
        bin_hit = s1_reg.enqueue_depth < limit_reg;
        for (int k = NUM_BINS - 2; k >= 0; k--)
        begin
            if (depth10 < edge_reg[k])
            begin
                bin = 4'(k);
                bin_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        row_next = row_cur;
        if (s1_reg.protocol == PROTO_TCP)
        begin
            row_next.tcp_pkts  = row_cur.tcp_pkts + 32'd1;
            row_next.tcp_bytes = row_cur.tcp_bytes + len64;
        end
        else
        begin
            row_next.udp_pkts  = row_cur.udp_pkts + 32'd1;
            row_next.udp_bytes = row_cur.udp_bytes + len64;
        end
        unique case (s1_reg.color)
            COLOR_GREEN:  row_next.colors[0] = row_cur.colors[0] + 32'd1;
            COLOR_YELLOW: row_next.colors[1] = row_cur.colors[1] + 32'd1;
            COLOR_RED:    row_next.colors[2] = row_cur.colors[2] + 32'd1;
            default:      row_next.colors = row_cur.colors;
        endcase
        if (bin_hit)
        begin
            row_next.hist[bin] = row_cur.hist[bin] + 32'd1;
        end
        row_next.depth_sum = row_cur.depth_sum + {32'd0, s1_reg.enqueue_depth};
        row_next.delay_sum = row_cur.delay_sum + {32'd0, delay_c};
        row_next.trans_sum = row_cur.trans_sum + {32'd0, transit};
        row_next.depth_mm  = track_min_max(row_cur.depth_mm, s1_reg.enqueue_depth);
        row_next.delay_mm  = track_min_max(row_cur.delay_mm, delay_c);
        row_next.trans_mm  = track_min_max(row_cur.trans_mm, transit);
    end

    always_comb
    begin
        out_next = '0;
        if (s1_reg.cmd == CMD_PACKET)
        begin
            if (s1_reg.protocol == PROTO_TCP || s1_reg.protocol == PROTO_UDP)
            begin
                out_next.corrected_delay = delay_c;
                out_next.counted = 1'b1;
            end
        end
        else if (s1_reg.cmd == CMD_READ)
        begin
            if (s1_reg.stat_index >= ST_HIST_FIRST && s1_reg.stat_index <= ST_HIST_LAST)
            begin
                out_next.read_data = {32'd0, row_cur.hist[4'(s1_reg.stat_index - ST_HIST_FIRST)]};
            end
            else
            begin
                unique case (s1_reg.stat_index)
                    ST_UDP_PKTS:    out_next.read_data = {32'd0, row_cur.udp_pkts};
                    ST_UDP_BYTES:   out_next.read_data = row_cur.udp_bytes;
                    ST_TCP_PKTS:    out_next.read_data = {32'd0, row_cur.tcp_pkts};
                    ST_TCP_BYTES:   out_next.read_data = row_cur.tcp_bytes;
                    ST_GREEN:       out_next.read_data = {32'd0, row_cur.colors[0]};
                    ST_YELLOW:      out_next.read_data = {32'd0, row_cur.colors[1]};
                    ST_RED:         out_next.read_data = {32'd0, row_cur.colors[2]};
                    ST_DEPTH_SUM:   out_next.read_data = row_cur.depth_sum;
                    ST_DELAY_SUM:   out_next.read_data = row_cur.delay_sum;
                    ST_TRANS_SUM:   out_next.read_data = row_cur.trans_sum;
                    ST_DEPTH_MIN:   out_next.read_data = {32'd0, row_cur.depth_mm.lo};
                    ST_DEPTH_MAX:   out_next.read_data = {32'd0, row_cur.depth_mm.hi};
                    ST_DELAY_MIN:   out_next.read_data = {32'd0, row_cur.delay_mm.lo};
                    ST_DELAY_MAX:   out_next.read_data = {32'd0, row_cur.delay_mm.hi};
                    ST_TRANS_MIN:   out_next.read_data = {32'd0, row_cur.trans_mm.lo};
                    ST_TRANS_MAX:   out_next.read_data = {32'd0, row_cur.trans_mm.hi};
                    ST_G_TCP_PKTS:  out_next.read_data = {32'd0, g_tcp_pkts_reg};
                    ST_G_TCP_BYTES: out_next.read_data = g_tcp_bytes_reg;
                    ST_G_UDP_PKTS:  out_next.read_data = {32'd0, g_udp_pkts_reg};
                    ST_G_UDP_BYTES: out_next.read_data = g_udp_bytes_reg;
                    ST_INGRESS_SEQ: out_next.read_data = iseq_reg;
                    ST_EGRESS_SEQ:  out_next.read_data = eseq_reg;
                    default:        out_next.read_data = 64'd0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BINS - 1; k++)
            begin
                edge_reg[k] <= 36'(MAX_DEPTH_RESET) * 36'(k + 1);
            end
            limit_reg <= HIST_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_DEPTH)
            begin
                for (int k = 0; k < NUM_BINS - 1; k++)
                begin
                    edge_reg[k] <= 36'(cfg_data[23:0]) * 36'(k + 1);
                end
            end
            else
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg <= req.data;
        end
        if (s1_valid_reg && advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                row_reg[i] <= '0;
            end
            g_tcp_pkts_reg  <= '0;
            g_udp_pkts_reg  <= '0;
            g_tcp_bytes_reg <= '0;
            g_udp_bytes_reg <= '0;
            iseq_reg        <= '0;
            eseq_reg        <= '0;
        end
        else if (do_clear)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                row_reg[i] <= '0;
            end
            g_tcp_pkts_reg  <= '0;
            g_udp_pkts_reg  <= '0;
            g_tcp_bytes_reg <= '0;
            g_udp_bytes_reg <= '0;
        end
        else if (do_count)
        begin
            row_reg[q] <= row_next;
            if (s1_reg.protocol == PROTO_TCP)
            begin
                g_tcp_pkts_reg  <= g_tcp_pkts_reg + 32'd1;
                g_tcp_bytes_reg <= g_tcp_bytes_reg + len64;
            end
            else
            begin
                g_udp_pkts_reg  <= g_udp_pkts_reg + 32'd1;
                g_udp_bytes_reg <= g_udp_bytes_reg + len64;
            end
            iseq_reg <= extend_seq(iseq_reg, s1_reg.ingress_seq_low);
            eseq_reg <= extend_seq(eseq_reg, s1_reg.egress_seq_low);
        end
    end

endmodule

### rtl/core/qts_checker.sv
// Port-level checks for the queue telemetry statistics engine.
// Depends on qts_pkg; bound to queue_telemetry_stats below.
module qts_checker
    import qts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // A counted record never carries read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.counted |-> rsp_data.read_data == 64'd0)
        else $error("counted item with read data");

    // A corrected delay only comes with a counted record.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.counted |-> rsp_data.corrected_delay == 32'd0)
        else $error("delay without counted record");

    // A stalled result holds its valid and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result dropped or changed");

endmodule

bind queue_telemetry_stats qts_checker u_qts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
